[sv/gvr_pkg.sv]
// ----------------------------------------------------------------------------
// gvr_pkg
// shared types and constants of the givens rotation generator
// ----------------------------------------------------------------------------
package gvr_pkg;

	localparam int DATA_W     = 32;
	localparam int SQ_W       = 2 * DATA_W;
	localparam int QUO_W      = SQ_W - 1;
	localparam int DIV_STEPS  = QUO_W;
	localparam int SQRT_STEPS = DATA_W;
	localparam logic [DATA_W-1:0] ONE_Q30 = DATA_W'(1) << 30;

	// per item flags that ride alongside the arithmetic
	typedef struct packed {
		logic differ;   // operand signs differ
		logic b_major;  // |b| > |a|
		logic zero;     // both operands are zero
	} side_t;

endpackage

[sv/gvr_front.sv]
// ----------------------------------------------------------------------------
// gvr_front
// magnitudes, squares and sum of squares, three pipeline stages
// ----------------------------------------------------------------------------
module gvr_front import gvr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DATA_W-1:0] in_a,
	input  logic [DATA_W-1:0] in_b,
	output logic              out_valid,
	output logic [SQ_W-1:0]   out_mag2_a,
	output logic [SQ_W-1:0]   out_mag2_b,
	output logic [SQ_W-1:0]   out_den,
	output side_t             out_side
);

	logic [DATA_W-1:0] mag_a, mag_b;
	logic [DATA_W-1:0] mag_a_s1, mag_b_s1;
	logic [SQ_W-1:0]   sq_a_s2, sq_b_s2;
	logic [SQ_W-1:0]   sq_a_s3, sq_b_s3, den_s3;
	side_t             side_s1, side_s2, side_s3;
	logic              valid_s1, valid_s2, valid_s3;

	// two's complement magnitudes, full scale negative gives 2^31
	assign mag_a = in_a[DATA_W-1] ? (~in_a + DATA_W'(1)) : in_a;
	assign mag_b = in_b[DATA_W-1] ? (~in_b + DATA_W'(1)) : in_b;

	// data stages
	always_ff @(posedge clk) begin
		if (en) begin
			mag_a_s1       <= mag_a;
			mag_b_s1       <= mag_b;
			side_s1.differ <= in_a[DATA_W-1] ^ in_b[DATA_W-1];
			side_s1.b_major <= mag_b > mag_a;
			side_s1.zero   <= (mag_a == '0) && (mag_b == '0);
			sq_a_s2        <= SQ_W'(mag_a_s1) * SQ_W'(mag_a_s1);
			sq_b_s2        <= SQ_W'(mag_b_s1) * SQ_W'(mag_b_s1);
			side_s2        <= side_s1;
			sq_a_s3        <= sq_a_s2;
			sq_b_s3        <= sq_b_s2;
			den_s3         <= sq_a_s2 + sq_b_s2;
			side_s3        <= side_s2;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign out_valid  = valid_s3;
	assign out_mag2_a = sq_a_s3;
	assign out_mag2_b = sq_b_s3;
	assign out_den    = den_s3;
	assign out_side   = side_s3;

endmodule

[sv/gvr_div.sv]
// ----------------------------------------------------------------------------
// gvr_div
// restoring division of mag^2 * 2^62 by r^2, one quotient bit per stage
// ----------------------------------------------------------------------------
module gvr_div import gvr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [SQ_W-1:0]  in_mag2_a,
	input  logic [SQ_W-1:0]  in_mag2_b,
	input  logic [SQ_W-1:0]  in_den,
	input  side_t            in_side,
	output logic             out_valid,
	output logic [QUO_W-1:0] out_quo_a,
	output logic [QUO_W-1:0] out_quo_b,
	output side_t            out_side
);

	logic [SQ_W-1:0]  rem_a_s [0:DIV_STEPS];
	logic [SQ_W-1:0]  rem_b_s [0:DIV_STEPS];
	logic [SQ_W-1:0]  den_s   [0:DIV_STEPS];
	logic [QUO_W-1:0] quo_a_s [0:DIV_STEPS];
	logic [QUO_W-1:0] quo_b_s [0:DIV_STEPS];
	side_t            side_s  [0:DIV_STEPS];
	logic             valid_s [0:DIV_STEPS];

	assign rem_a_s[0] = in_mag2_a;
	assign rem_b_s[0] = in_mag2_b;
	assign den_s[0]   = in_den;
	assign quo_a_s[0] = '0;
	assign quo_b_s[0] = '0;
	assign side_s[0]  = in_side;
	assign valid_s[0] = in_valid;

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [SQ_W-1:0] dbl_a, dbl_b;
		logic            ge_a, ge_b;

		// first step takes the top bit without doubling
		always_comb begin
			dbl_a = (j == 0) ? rem_a_s[j] : {rem_a_s[j][SQ_W-2:0], 1'b0};
			dbl_b = (j == 0) ? rem_b_s[j] : {rem_b_s[j][SQ_W-2:0], 1'b0};
			ge_a  = dbl_a >= den_s[j];
			ge_b  = dbl_b >= den_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_a_s[j+1] <= ge_a ? (dbl_a - den_s[j]) : dbl_a;
				rem_b_s[j+1] <= ge_b ? (dbl_b - den_s[j]) : dbl_b;
				quo_a_s[j+1] <= {quo_a_s[j][QUO_W-2:0], ge_a};
				quo_b_s[j+1] <= {quo_b_s[j][QUO_W-2:0], ge_b};
				den_s[j+1]   <= den_s[j];
				side_s[j+1]  <= side_s[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else if (en) begin
				valid_s[j+1] <= valid_s[j];
			end
		end
	end

	assign out_valid = valid_s[DIV_STEPS];
	assign out_quo_a = quo_a_s[DIV_STEPS];
	assign out_quo_b = quo_b_s[DIV_STEPS];
	assign out_side  = side_s[DIV_STEPS];

endmodule

[sv/gvr_isqrt.sv]
// ----------------------------------------------------------------------------
// gvr_isqrt
// integer square root of both quotients, one root bit per stage
// ----------------------------------------------------------------------------
module gvr_isqrt import gvr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [QUO_W-1:0]  in_quo_a,
	input  logic [QUO_W-1:0]  in_quo_b,
	input  side_t             in_side,
	output logic              out_valid,
	output logic [DATA_W-1:0] out_root_a,
	output logic [DATA_W-1:0] out_root_b,
	output side_t             out_side
);

	localparam int TW = SQ_W + 2;

	logic [SQ_W-1:0]   rem_a_s  [0:SQRT_STEPS];
	logic [SQ_W-1:0]   rem_b_s  [0:SQRT_STEPS];
	logic [DATA_W-1:0] root_a_s [0:SQRT_STEPS];
	logic [DATA_W-1:0] root_b_s [0:SQRT_STEPS];
	side_t             side_s   [0:SQRT_STEPS];
	logic              valid_s  [0:SQRT_STEPS];

	assign rem_a_s[0]  = SQ_W'(in_quo_a);
	assign rem_b_s[0]  = SQ_W'(in_quo_b);
	assign root_a_s[0] = '0;
	assign root_b_s[0] = '0;
	assign side_s[0]   = in_side;
	assign valid_s[0]  = in_valid;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam int BIT = SQRT_STEPS - 1 - k;
		logic [TW-1:0] trial_a, trial_b;
		logic          ge_a, ge_b;

		// (root + 2^i)^2 - root^2 = root * 2^(i+1) + 2^(2i)
		always_comb begin
			trial_a = (TW'(root_a_s[k]) << (BIT + 1)) + (TW'(1) << (2 * BIT));
			trial_b = (TW'(root_b_s[k]) << (BIT + 1)) + (TW'(1) << (2 * BIT));
			ge_a    = TW'(rem_a_s[k]) >= trial_a;
			ge_b    = TW'(rem_b_s[k]) >= trial_b;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_a_s[k+1]  <= ge_a ? (rem_a_s[k] - trial_a[SQ_W-1:0]) : rem_a_s[k];
				rem_b_s[k+1]  <= ge_b ? (rem_b_s[k] - trial_b[SQ_W-1:0]) : rem_b_s[k];
				root_a_s[k+1] <= root_a_s[k] | (ge_a ? (DATA_W'(1) << BIT) : '0);
				root_b_s[k+1] <= root_b_s[k] | (ge_b ? (DATA_W'(1) << BIT) : '0);
				side_s[k+1]   <= side_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end
	end

	assign out_valid  = valid_s[SQRT_STEPS];
	assign out_root_a = root_a_s[SQRT_STEPS];
	assign out_root_b = root_b_s[SQRT_STEPS];
	assign out_side   = side_s[SQRT_STEPS];

`ifndef SYNTHESIS
	// a root never exceeds 2^31 because the quotient is at most 2^62
	a_root_a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_side.zero |-> out_root_a <= (DATA_W'(1) << (DATA_W - 1)))
		else $error("root a out of range");
	a_root_b_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_side.zero |-> out_root_b <= (DATA_W'(1) << (DATA_W - 1)))
		else $error("root b out of range");
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_side.zero |-> !out_side.b_major)
		else $error("zero item flagged b major");
`endif

endmodule

[sv/givens_rotation_generator.sv]
// ----------------------------------------------------------------------------
// givens_rotation_generator
// negated givens rotation matrix from a vector (a, b), Q16.16 in, Q2.30 out
// ----------------------------------------------------------------------------
// usage:
//   s_tdata carries one item: first_value in [31:0], second_value in [63:32].
//   m_tdata returns the four matrix entries -c, +s, -s, -c as 32-bit Q2.30
//   words, entry_row0_col0 in the lowest bits.
//   c and s are |a|/r and |b|/r in magnitude, rounded half up from the truncated root.
// pipeline: 3 front stages (magnitude, square, sum), 63 division stages,
//   one per quotient bit, 32 square root stages, one per root bit, and the
//   output register.
// throughput: one item per cycle while no result stalls, every stage advances together.
// stall: while a result waits and m_tready is low the whole pipeline holds
//   and s_tready is low; nothing is lost or repeated.
// reset: arst_n clears all valid bits at once; the block is then empty
//   and ready.
// ----------------------------------------------------------------------------
module givens_rotation_generator import gvr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [2*DATA_W-1:0] s_tdata,  // first_value, second_value
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [4*DATA_W-1:0] m_tdata   // row0_col0, row0_col1, row1_col0, row1_col1
);

	logic              en;
	logic              fr_valid, dv_valid, sq_valid;
	logic [SQ_W-1:0]   fr_mag2_a, fr_mag2_b, fr_den;
	logic [QUO_W-1:0]  dv_quo_a, dv_quo_b;
	logic [DATA_W-1:0] sq_root_a, sq_root_b;
	side_t             fr_side, dv_side, sq_side;
	logic [DATA_W:0]   rnd_a, rnd_b;
	logic [DATA_W-1:0] cm, sm, c_val, s_val;
	logic [DATA_W-1:0] e00_q, e01_q, e10_q, e11_q;
	logic              valid_q;

	// global advance
	assign en       = !valid_q || m_tready;
	assign s_tready = en;

	gvr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_tvalid),
		.in_a       (s_tdata[DATA_W-1:0]),
		.in_b       (s_tdata[2*DATA_W-1:DATA_W]),
		.out_valid  (fr_valid),
		.out_mag2_a (fr_mag2_a),
		.out_mag2_b (fr_mag2_b),
		.out_den    (fr_den),
		.out_side   (fr_side)
	);

	gvr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.in_mag2_a (fr_mag2_a),
		.in_mag2_b (fr_mag2_b),
		.in_den    (fr_den),
		.in_side   (fr_side),
		.out_valid (dv_valid),
		.out_quo_a (dv_quo_a),
		.out_quo_b (dv_quo_b),
		.out_side  (dv_side)
	);

	gvr_isqrt u_isqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (dv_valid),
		.in_quo_a   (dv_quo_a),
		.in_quo_b   (dv_quo_b),
		.in_side    (dv_side),
		.out_valid  (sq_valid),
		.out_root_a (sq_root_a),
		.out_root_b (sq_root_b),
		.out_side   (sq_side)
	);

	// round half up from the doubled-scale root, then apply sign rules
	always_comb begin
		rnd_a = (DATA_W + 1)'(sq_root_a) + (DATA_W + 1)'(1);
		rnd_b = (DATA_W + 1)'(sq_root_b) + (DATA_W + 1)'(1);
		cm    = rnd_a[DATA_W:1];
		sm    = rnd_b[DATA_W:1];
		if (sq_side.zero) begin
			c_val = ONE_Q30;
			s_val = '0;
		end else if (sq_side.b_major) begin
			s_val = sm;
			c_val = sq_side.differ ? cm : (~cm + DATA_W'(1));
		end else begin
			c_val = cm;
			s_val = sq_side.differ ? sm : (~sm + DATA_W'(1));
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			e00_q <= ~c_val + DATA_W'(1);
			e01_q <= s_val;
			e10_q <= ~s_val + DATA_W'(1);
			e11_q <= ~c_val + DATA_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= sq_valid;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {e11_q, e10_q, e01_q, e00_q};

`ifndef SYNTHESIS
	// both diagonal entries carry minus cosine
	a_diag_equal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> e00_q == e11_q)
		else $error("diagonal entries differ");
	// off diagonal entries are negatives of each other
	a_offdiag_neg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (e01_q + e10_q) == '0)
		else $error("off diagonal entries not opposite");
	// ready follows the output register occupancy
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready does not track output register");
	// a stalled result register keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(e00_q) && $stable(e01_q) && m_tvalid)
		else $error("stalled result changed");
`endif

endmodule
